>>> rtl/fce_pkg.sv
// Shared types and constants of the chained block allocation table engine.
// Used by fat_chain_engine; depends on nothing else.
package fce_pkg;

  localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_WALK   = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [13:0] DBC_RESET = 14'd8192;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] start_block;
    logic [13:0] skip_count;
    logic [15:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] block_out;
    logic [1:0]  status;
    logic [13:0] entry_count;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_WAIT,
    S_SCAN,
    S_APP_LINK,
    S_APP_MARK,
    S_FREE,
    S_FREE_WAIT
  } state_t;

endpackage

>>> rtl/fce_ram.sv
// Generic RAM with one write port and one read port, read data registered.
// Holds the allocation table of fat_chain_engine; no dependencies.
module fce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fat_chain_engine.sv
// Top level of the chained block allocation table engine.
// Depends on fce_pkg and fce_ram.
//
// One command is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// cannot stall it. After reset the block clears every table entry to zero,
// busy high, while the block limit register is already writable.
// All table work goes through one memory with one write port and a registered
// read. Load writes one entry; walk follows links from the start block; free
// chain clears entries until the end mark, an inactive entry or one already
// free; append takes the lowest free entry of the active range, or reports
// full; count free scans the active range; an append to an inactive tail or
// an unknown operation is answered with a range status. Writes to the block
// limit register are taken every cycle and belong only in idle periods.
module fat_chain_engine #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fce_pkg::cmd_t command,
  output logic          done,
  output fce_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [13:0]   cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);
  localparam logic [15:0] LAST_IDX = 16'(TABLE_DEPTH - 1);

  fce_pkg::state_t state, state_next;
  logic [2:0]  op, op_next;
  logic [15:0] cur, cur_next;
  logic [13:0] skip, skip_next;
  logic [15:0] val, val_next;
  logic [15:0] found, found_next;
  logic [15:0] idx, idx_next;
  logic [13:0] steps, steps_next;
  logic [13:0] cnt, cnt_next;
  logic        rd_pend, rd_pend_next;
  logic [15:0] rd_idx, rd_idx_next;
  logic        done_r;
  logic        done_next;
  fce_pkg::res_t res, res_next;
  logic [13:0] dbc;
  logic [15:0] lim;
  logic        issue;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  fce_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state != fce_pkg::S_IDLE);
  assign done      = done_r;
  assign result    = res;
  assign cfg_ready = 1'b1;

  always_comb begin
    lim = ({3'b000, dbc} > DEPTH17) ? DEPTH17[15:0] : {2'b00, dbc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbc <= fce_pkg::DBC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dbc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fce_pkg::S_CLEAR;
      idx     <= '0;
      done_r  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      done_r  <= done_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    cur    <= cur_next;
    skip   <= skip_next;
    val    <= val_next;
    found  <= found_next;
    steps  <= steps_next;
    cnt    <= cnt_next;
    rd_idx <= rd_idx_next;
    res    <= res_next;
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    cur_next     = cur;
    skip_next    = skip;
    val_next     = val;
    found_next   = found;
    idx_next     = idx;
    steps_next   = steps;
    cnt_next     = cnt;
    rd_pend_next = 1'b0;
    rd_idx_next  = rd_idx;
    done_next    = 1'b0;
    res_next     = res;
    we           = 1'b0;
    waddr        = cur[AW-1:0];
    wdata        = '0;
    raddr        = cur[AW-1:0];
    issue        = 1'b0;
    unique case (state)
      fce_pkg::S_CLEAR: begin
        we       = 1'b1;
        waddr    = idx[AW-1:0];
        idx_next = idx + 16'd1;
        if (idx == LAST_IDX) begin
          state_next = fce_pkg::S_IDLE;
        end
      end
      fce_pkg::S_IDLE: begin
        if (start) begin
          op_next    = command.operation;
          cur_next   = command.start_block;
          skip_next  = command.skip_count;
          val_next   = command.entry_value;
          state_next = fce_pkg::S_DECODE;
        end
      end
      fce_pkg::S_DECODE: begin
        steps_next = '0;
        cnt_next   = '0;
        idx_next   = '0;
        unique case (op)
          fce_pkg::OP_LOAD: begin
            state_next = fce_pkg::S_IDLE;
            done_next  = 1'b1;
            if ({1'b0, cur} < DEPTH17) begin
              we       = 1'b1;
              wdata    = val;
              res_next = '{block_out: cur, status: fce_pkg::ST_OK, entry_count: '0};
            end else begin
              res_next = '{block_out: cur, status: fce_pkg::ST_RANGE, entry_count: '0};
            end
          end
          fce_pkg::OP_WALK: begin
            state_next = fce_pkg::S_WALK;
          end
          fce_pkg::OP_APPEND: begin
            if (cur != fce_pkg::END_OF_CHAIN && cur >= lim) begin
              state_next = fce_pkg::S_IDLE;
              done_next  = 1'b1;
              res_next   = '{block_out: fce_pkg::END_OF_CHAIN,
                             status: fce_pkg::ST_RANGE, entry_count: '0};
            end else begin
              state_next = fce_pkg::S_SCAN;
            end
          end
          fce_pkg::OP_FREE: begin
            state_next = fce_pkg::S_FREE;
          end
          fce_pkg::OP_COUNT: begin
            state_next = fce_pkg::S_SCAN;
          end
          default: begin
            state_next = fce_pkg::S_IDLE;
            done_next  = 1'b1;
            res_next   = '{block_out: fce_pkg::END_OF_CHAIN,
                           status: fce_pkg::ST_RANGE, entry_count: '0};
          end
        endcase
      end
      fce_pkg::S_WALK: begin
        if (steps == skip || cur == fce_pkg::END_OF_CHAIN) begin
          state_next = fce_pkg::S_IDLE;
          done_next  = 1'b1;
          res_next   = '{block_out: cur, status: fce_pkg::ST_OK, entry_count: '0};
        end else if (cur >= lim) begin
          state_next = fce_pkg::S_IDLE;
          done_next  = 1'b1;
          res_next   = '{block_out: cur, status: fce_pkg::ST_RANGE, entry_count: '0};
        end else begin
          state_next = fce_pkg::S_WALK_WAIT;
        end
      end
      fce_pkg::S_WALK_WAIT: begin
        cur_next   = rdata;
        steps_next = steps + 14'd1;
        state_next = fce_pkg::S_WALK;
      end
      fce_pkg::S_SCAN: begin
        raddr        = idx[AW-1:0];
        issue        = (idx < lim);
        rd_pend_next = issue;
        rd_idx_next  = idx;
        if (issue) begin
          idx_next = idx + 16'd1;
        end
        if (rd_pend && rdata == 16'd0 && op == fce_pkg::OP_APPEND) begin
          found_next   = rd_idx;
          rd_pend_next = 1'b0;
          state_next   = fce_pkg::S_APP_LINK;
        end else begin
          if (rd_pend && rdata == 16'd0) begin
            cnt_next = cnt + 14'd1;
          end
          if (!rd_pend && !issue) begin
            state_next = fce_pkg::S_IDLE;
            done_next  = 1'b1;
            if (op == fce_pkg::OP_APPEND) begin
              res_next = '{block_out: fce_pkg::END_OF_CHAIN,
                           status: fce_pkg::ST_FULL, entry_count: '0};
            end else begin
              res_next = '{block_out: fce_pkg::END_OF_CHAIN,
                           status: fce_pkg::ST_OK, entry_count: cnt};
            end
          end
        end
      end
      fce_pkg::S_APP_LINK: begin
        we         = (cur != fce_pkg::END_OF_CHAIN);
        wdata      = found;
        state_next = fce_pkg::S_APP_MARK;
      end
      fce_pkg::S_APP_MARK: begin
        we         = 1'b1;
        waddr      = found[AW-1:0];
        wdata      = fce_pkg::END_OF_CHAIN;
        state_next = fce_pkg::S_IDLE;
        done_next  = 1'b1;
        res_next   = '{block_out: found, status: fce_pkg::ST_OK, entry_count: '0};
      end
      fce_pkg::S_FREE: begin
        if (cur == fce_pkg::END_OF_CHAIN || cur >= lim) begin
          state_next = fce_pkg::S_IDLE;
          done_next  = 1'b1;
          res_next   = '{block_out: fce_pkg::END_OF_CHAIN,
                         status: fce_pkg::ST_OK, entry_count: cnt};
        end else begin
          state_next = fce_pkg::S_FREE_WAIT;
        end
      end
      fce_pkg::S_FREE_WAIT: begin
        if (rdata == 16'd0) begin
          state_next = fce_pkg::S_IDLE;
          done_next  = 1'b1;
          res_next   = '{block_out: fce_pkg::END_OF_CHAIN,
                         status: fce_pkg::ST_OK, entry_count: cnt};
        end else begin
          we         = 1'b1;
          cnt_next   = cnt + 14'd1;
          cur_next   = rdata;
          state_next = fce_pkg::S_FREE;
        end
      end
      default: begin
        state_next = fce_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted command did not raise busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe held for more than one cycle.");

  a_full_eoc: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == fce_pkg::ST_FULL) |->
      (result.block_out == fce_pkg::END_OF_CHAIN && result.entry_count == 14'd0))
    else $error("Full result carries a block number or count.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result delivered while the engine is still busy.");
`endif

endmodule
